// File: rtl/qfa_pkg.sv
// Package for the binary128 truncating adder: payload structs and constants.
// No dependencies.
package qfa_pkg;

    localparam int unsigned ExpW  = 15;
    localparam int unsigned FracW = 112;
    localparam int unsigned SigW  = 113;
    localparam logic [ExpW-1:0] ExpMax = 15'h7FFF;

    typedef struct packed {
        logic        a_sign;
        logic [14:0] a_exponent;
        logic [47:0] a_fraction_high;
        logic [63:0] a_fraction_low;
        logic        b_sign;
        logic [14:0] b_exponent;
        logic [47:0] b_fraction_high;
        logic [63:0] b_fraction_low;
    } t_qfa_in;

    typedef struct packed {
        logic        sum_sign;
        logic [14:0] sum_exponent;
        logic [47:0] sum_fraction_high;
        logic [63:0] sum_fraction_low;
        logic        exponent_overflow;
        logic        exponent_underflow;
    } t_qfa_out;

endpackage

// File: rtl/qfa_core.sv
// Combinational add path of the binary128 truncating adder.
// Depends on qfa_pkg.
module qfa_core (
    input  qfa_pkg::t_qfa_in  i_op,
    output qfa_pkg::t_qfa_out o_res
);
    import qfa_pkg::*;

    logic             a_big;
    logic [ExpW-1:0]  big_e;
    logic             big_s;
    logic [SigW-1:0]  sig_a, sig_b, sig_big, sig_sml, sig_shf;
    logic [ExpW-1:0]  diff;
    logic [SigW:0]    sum;
    logic [ExpW:0]    e_inc;
    logic             sml_gt;
    logic [SigW-1:0]  mag_hi, mag_lo, dif;
    logic             dif_s;
    logic [6:0]       lead;
    logic [6:0]       k;
    logic [SigW-1:0]  dif_n;

    always_comb begin
        sig_a = {1'b1, i_op.a_fraction_high, i_op.a_fraction_low};
        sig_b = {1'b1, i_op.b_fraction_high, i_op.b_fraction_low};
        a_big = (i_op.a_exponent >= i_op.b_exponent);
        big_e = a_big ? i_op.a_exponent : i_op.b_exponent;
        big_s = a_big ? i_op.a_sign : i_op.b_sign;
        sig_big = a_big ? sig_a : sig_b;
        sig_sml = a_big ? sig_b : sig_a;
        diff = a_big ? (i_op.a_exponent - i_op.b_exponent)
                     : (i_op.b_exponent - i_op.a_exponent);
        sig_shf = (diff >= ExpW'(SigW)) ? '0 : (sig_sml >> diff);
        sum = {1'b0, sig_big} + {1'b0, sig_shf};
        e_inc = {1'b0, big_e} + (ExpW+1)'(1);
        sml_gt = (sig_shf > sig_big);
        mag_hi = sml_gt ? sig_shf : sig_big;
        mag_lo = sml_gt ? sig_big : sig_shf;
        dif_s = sml_gt ? ~big_s : big_s;
        dif = mag_hi - mag_lo;
        // leading-one position
        lead = '0;
        for (int i = 0; i < SigW; i++) begin
            if (dif[i]) lead = 7'(i);
        end
        k = 7'(FracW) - lead;
        dif_n = dif << k;

        o_res = '0;
        priority if (i_op.a_exponent == '0 && i_op.b_exponent == '0) begin
            o_res.sum_sign = i_op.a_sign & i_op.b_sign;
        end else if (i_op.a_exponent == '0) begin
            o_res.sum_sign = i_op.b_sign;
            o_res.sum_exponent = i_op.b_exponent;
            o_res.sum_fraction_high = i_op.b_fraction_high;
            o_res.sum_fraction_low = i_op.b_fraction_low;
        end else if (i_op.b_exponent == '0) begin
            o_res.sum_sign = i_op.a_sign;
            o_res.sum_exponent = i_op.a_exponent;
            o_res.sum_fraction_high = i_op.a_fraction_high;
            o_res.sum_fraction_low = i_op.a_fraction_low;
        end else if (i_op.a_sign == i_op.b_sign) begin
            o_res.sum_sign = i_op.a_sign;
            if (sum[SigW]) begin
                if (e_inc[ExpW]) begin
                    o_res.sum_exponent = ExpMax;
                    o_res.exponent_overflow = 1'b1;
                end else begin
                    o_res.sum_exponent = e_inc[ExpW-1:0];
                    {o_res.sum_fraction_high, o_res.sum_fraction_low} = sum[FracW:1];
                end
            end else begin
                o_res.sum_exponent = big_e;
                {o_res.sum_fraction_high, o_res.sum_fraction_low} = sum[FracW-1:0];
            end
        end else if (dif == '0) begin
            o_res = '0;
        end else if ({8'd0, k} >= big_e) begin
            o_res.sum_sign = dif_s;
            o_res.exponent_underflow = 1'b1;
        end else begin
            o_res.sum_sign = dif_s;
            o_res.sum_exponent = big_e - {8'd0, k};
            {o_res.sum_fraction_high, o_res.sum_fraction_low} = dif_n[FracW-1:0];
        end
    end
endmodule

// File: rtl/quad_float_adder.sv
// Top level of the binary128 truncating adder: input and result registers.
// Depends on qfa_pkg and qfa_core.
//
//  channel | valid      | ready      | payload
//  input   | i_in_valid | o_in_ready | i_in_data  (t_qfa_in)
//  result  | o_out_valid| i_out_ready| o_out_data (t_qfa_out)
//
// One item per cycle sustained while i_out_ready keeps the result register draining;
// an accepted input passes through the input register, then the add path into
// the result register, where the sum goes valid.
// Reset (i_rst_n low, synchronous) empties both registers.
// A stalled result holds both stages; a stage advances when the one after it
// is empty or handing its item on in the same cycle.
module quad_float_adder (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  qfa_pkg::t_qfa_in   i_in_data,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output qfa_pkg::t_qfa_out  o_out_data
);
    import qfa_pkg::*;

    logic      r_s1_valid, r_s2_valid;
    t_qfa_in   r_s1_data;
    t_qfa_out  r_s2_data;
    t_qfa_out  n_s2_data;
    logic      s2_adv, s1_adv;

    qfa_core u_core (
        .i_op  (r_s1_data),
        .o_res (n_s2_data)
    );

    // advance result stage when empty or drained
    assign s2_adv     = !r_s2_valid || i_out_ready;
    assign s1_adv     = !r_s1_valid || s2_adv;
    assign o_in_ready = s1_adv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            r_s2_valid <= 1'b0;
        end else begin
            if (s1_adv) r_s1_valid <= i_in_valid;
            if (s2_adv) r_s2_valid <= r_s1_valid;
        end
        if (s1_adv && i_in_valid) r_s1_data <= i_in_data;
        if (s2_adv && r_s1_valid) r_s2_data <= n_s2_data;
    end

    assign o_out_valid = r_s2_valid;
    assign o_out_data  = r_s2_data;
endmodule
